/* design/trap_pkg.sv */
// ----------------------------------------------------------------------------
// trap_pkg
// Shared types, constants and helpers for the trapezoidal profile generator.
// ----------------------------------------------------------------------------
package trap_pkg;

  localparam int POS_W  = 32;
  localparam int FRAC_W = 16;
  localparam int TICKS  = 1000;
  localparam int ACC_W  = 31;
  localparam int DLY_W  = 10;
  localparam int SPD_W  = 31;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 33;
  localparam int CNT_W  = 6;

  localparam logic [31:0]      SPEED_RESET = 32'(100 << FRAC_W);
  localparam logic [31:0]      ACCEL_RESET = 32'(50 << FRAC_W);
  localparam logic [ACC_W-1:0] ACC_CFG_RESET = 31'd3276800;
  localparam logic [DLY_W-1:0] DLY_CFG_RESET = 10'd500;
  localparam logic [32:0]      HALF_TICK = 33'(TICKS / 2);
  localparam logic             KIND_GOTO = 1'b1;

  // n / TICKS = (n >> 3) / (TICKS / 8), the odd part by reciprocal multiply
  localparam int               RECIP_SH   = 37;
  localparam longint           TICK_ODD   = TICKS / 8;
  localparam logic [30:0]      TICK_RECIP = 31'(((64'd1 << RECIP_SH) + TICK_ODD - 1) / TICK_ODD);

  localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_REQ  = 3'd1,
    MODE_ACC  = 3'd2,
    MODE_BRK  = 3'd3,
    MODE_DONE = 3'd4
  } mode_t;

  typedef enum logic [0:0] {
    CFG_ACCEL = 1'b0,
    CFG_DELAY = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GOTO, OP_SIMPLE, OP_DIV_A, OP_VEL, OP_DIV_V,
    OP_POS, OP_MUL, OP_DIV_D, OP_DECIDE, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    C_IDLE, C_DISP, C_WAIT_A, C_VEL, C_DIVV, C_WAIT_V, C_POS, C_MUL,
    C_DIVD, C_WAIT_D, C_DECIDE, C_OUT
  } ctrl_state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic  kind;
    mode_t mode;
    logic  out_full;
    logic  div_done;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S32_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* design/trap_div.sv */
// ----------------------------------------------------------------------------
// trap_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trap_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [trap_pkg::DVD_W-1:0]    dividend,
  input  logic [trap_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [trap_pkg::DVD_W-1:0]    quotient
);

  logic [trap_pkg::DVS_W-1:0] rem;
  logic [trap_pkg::DVD_W-1:0] dq;
  logic [trap_pkg::CNT_W-1:0] count;
  logic                       busy;
  logic [trap_pkg::DVS_W:0]   trial;
  logic                       take;

  assign trial    = {rem, dq[trap_pkg::DVD_W-1]};
  assign take     = trial >= {1'b0, divisor};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= take ? trap_pkg::DVS_W'(trial - {1'b0, divisor}) : trial[trap_pkg::DVS_W-1:0];
      dq  <= {dq[trap_pkg::DVD_W-2:0], take};
    end
  end

endmodule

/* design/trap_ctrl.sv */
// ----------------------------------------------------------------------------
// trap_ctrl
// Sequencer: steps each item through the datapath operations.
// ----------------------------------------------------------------------------
module trap_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trap_pkg::status_t stat,
  output trap_pkg::cmd_t    cmd
);

  trap_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= trap_pkg::C_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = trap_pkg::OP_NONE;
    in_ready   = 1'b0;
    case (state)
      trap_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = trap_pkg::OP_LOAD;
          state_next = trap_pkg::C_DISP;
        end
      end
      trap_pkg::C_DISP: begin
        if (stat.kind == trap_pkg::KIND_GOTO) begin
          cmd.op     = trap_pkg::OP_GOTO;
          state_next = trap_pkg::C_OUT;
        end else if (stat.mode == trap_pkg::MODE_ACC || stat.mode == trap_pkg::MODE_BRK) begin
          cmd.op     = trap_pkg::OP_DIV_A;
          state_next = trap_pkg::C_WAIT_A;
        end else begin
          cmd.op     = trap_pkg::OP_SIMPLE;
          state_next = trap_pkg::C_OUT;
        end
      end
      // reciprocal product registers here
      trap_pkg::C_WAIT_A: state_next = trap_pkg::C_VEL;
      trap_pkg::C_VEL: begin
        cmd.op     = trap_pkg::OP_VEL;
        state_next = trap_pkg::C_DIVV;
      end
      trap_pkg::C_DIVV: begin
        cmd.op     = trap_pkg::OP_DIV_V;
        state_next = trap_pkg::C_WAIT_V;
      end
      trap_pkg::C_WAIT_V: state_next = trap_pkg::C_POS;
      trap_pkg::C_POS: begin
        cmd.op     = trap_pkg::OP_POS;
        state_next = (stat.mode == trap_pkg::MODE_ACC) ? trap_pkg::C_MUL : trap_pkg::C_DECIDE;
      end
      trap_pkg::C_MUL: begin
        cmd.op     = trap_pkg::OP_MUL;
        state_next = trap_pkg::C_DIVD;
      end
      trap_pkg::C_DIVD: begin
        cmd.op     = trap_pkg::OP_DIV_D;
        state_next = trap_pkg::C_WAIT_D;
      end
      trap_pkg::C_WAIT_D: if (stat.div_done) state_next = trap_pkg::C_DECIDE;
      trap_pkg::C_DECIDE: begin
        cmd.op     = trap_pkg::OP_DECIDE;
        state_next = trap_pkg::C_OUT;
      end
      trap_pkg::C_OUT: begin
        if (!stat.out_full) begin
          cmd.op     = trap_pkg::OP_OUT;
          state_next = trap_pkg::C_IDLE;
        end
      end
      default: state_next = trap_pkg::C_IDLE;
    endcase
  end

endmodule

/* design/trap_dp.sv */
// ----------------------------------------------------------------------------
// trap_dp
// Datapath: profile state, config registers, divider, output register.
// ----------------------------------------------------------------------------
module trap_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [trap_pkg::ACC_W-1:0]      cfg_data,
  input  logic                            kind,
  input  logic signed [trap_pkg::POS_W-1:0] target_position,
  input  logic [trap_pkg::SPD_W-1:0]      target_speed,
  input  logic signed [trap_pkg::POS_W-1:0] measured_position,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [trap_pkg::POS_W-1:0] commanded_position,
  output logic [2:0]                      mode,
  output logic                            at_speed,
  output logic signed [31:0]              profile_speed,
  input  trap_pkg::cmd_t                  cmd,
  output trap_pkg::status_t               stat
);

  logic [trap_pkg::ACC_W-1:0] acceleration;
  logic [trap_pkg::DLY_W-1:0] start_delay;

  trap_pkg::mode_t            mode_reg;
  logic signed [31:0]         target_reg, speed_limit, accel_s, velocity, setpoint;
  logic [trap_pkg::SPD_W-1:0] nominal;
  logic [trap_pkg::DLY_W-1:0] delay_count;
  logic                       forward, speed_reached;

  logic                       in_kind;
  logic signed [31:0]         in_tpos, in_meas;
  logic [trap_pkg::SPD_W-1:0] in_tspd;

  logic                       q_neg;
  logic [63:0]                prod;

  logic                       div_start, div_done;
  logic [trap_pkg::DVD_W-1:0] dividend, quotient;
  logic [trap_pkg::DVS_W-1:0] divisor;

  logic [31:0]        tick_src;
  logic [32:0]        tick_sum;
  logic [29:0]        tick_num;
  logic [60:0]        tick_prod;
  logic [23:0]        tick_q;

  logic [31:0]        vel_mag, acc_mag, lim_mag, vs_mag, a_eff;
  logic signed [33:0] pt, vsum;
  logic signed [31:0] vs, pos_new;
  logic signed [32:0] rem;
  logic signed [65:0] rem_x, dist_x;
  logic               brake_now, fwd_req;

  assign vel_mag = velocity[31] ? 32'(-velocity) : velocity;
  assign acc_mag = accel_s[31] ? 32'(-accel_s) : accel_s;
  assign lim_mag = speed_limit[31] ? 32'(-speed_limit) : speed_limit;
  assign a_eff   = (acceleration == '0) ? 32'd1 : {1'b0, acceleration};
  assign fwd_req = target_reg >= in_meas;

  // per-tick share, rounded half away from zero: (|x| + 500) / 1000
  assign tick_src  = (cmd.op == trap_pkg::OP_DIV_V) ? vel_mag : acc_mag;
  assign tick_sum  = {1'b0, tick_src} + trap_pkg::HALF_TICK;
  assign tick_prod = tick_num * trap_pkg::TICK_RECIP;

  // per-tick increment, sign restored
  assign pt = q_neg ? -$signed({10'b0, tick_q}) : $signed({10'b0, tick_q});

  assign vsum = (mode_reg == trap_pkg::MODE_BRK)
              ? ({{2{velocity[31]}}, velocity} - pt)
              : ({{2{velocity[31]}}, velocity} + pt);
  assign vs      = trap_pkg::sat32(vsum);
  assign vs_mag  = vs[31] ? 32'(-vs) : vs;
  assign pos_new = trap_pkg::sat32({{2{setpoint[31]}}, setpoint} + pt);

  assign rem       = {target_reg[31], target_reg} - {setpoint[31], setpoint};
  assign rem_x     = {{33{rem[32]}}, rem};
  assign dist_x    = {2'b00, quotient};
  assign brake_now = forward ? (rem_x < dist_x) : (rem_x > -dist_x);

  // braking distance v^2 / (2a) on the serial divider
  assign div_start = (cmd.op == trap_pkg::OP_DIV_D);
  assign dividend  = prod;
  assign divisor   = {acc_mag, 1'b0};

  trap_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acceleration <= trap_pkg::ACC_CFG_RESET;
      start_delay  <= trap_pkg::DLY_CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == trap_pkg::CFG_ACCEL) acceleration <= cfg_data;
      else start_delay <= cfg_data[trap_pkg::DLY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= trap_pkg::MODE_IDLE;
      target_reg    <= '0;
      nominal       <= trap_pkg::SPD_W'(trap_pkg::SPEED_RESET);
      speed_limit   <= trap_pkg::SPEED_RESET;
      accel_s       <= trap_pkg::ACCEL_RESET;
      velocity      <= '0;
      setpoint      <= '0;
      delay_count   <= '0;
      forward       <= 1'b0;
      speed_reached <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= (cmd.op == trap_pkg::OP_OUT) || (out_valid && !out_ready);
      case (cmd.op)
        trap_pkg::OP_GOTO: begin
          target_reg <= in_tpos;
          nominal    <= in_tspd;
          if (mode_reg == trap_pkg::MODE_IDLE) begin
            if (delay_count == '0) delay_count <= start_delay;
            mode_reg <= trap_pkg::MODE_REQ;
          end
        end
        trap_pkg::OP_SIMPLE: begin
          case (mode_reg)
            trap_pkg::MODE_IDLE: speed_reached <= 1'b0;
            trap_pkg::MODE_REQ: begin
              forward     <= fwd_req;
              accel_s     <= fwd_req ? a_eff : 32'(-a_eff);
              speed_limit <= fwd_req ? {1'b0, nominal} : -$signed({1'b0, nominal});
              if (delay_count != '0) begin
                delay_count <= delay_count - 1'b1;
              end else begin
                velocity <= '0;
                mode_reg <= trap_pkg::MODE_ACC;
              end
            end
            default: begin
              setpoint <= target_reg;
              mode_reg <= trap_pkg::MODE_IDLE;
            end
          endcase
        end
        trap_pkg::OP_VEL: begin
          if (mode_reg == trap_pkg::MODE_ACC && vs_mag > lim_mag) begin
            speed_reached <= 1'b1;
            velocity      <= speed_limit;
          end else begin
            velocity <= vs;
          end
        end
        trap_pkg::OP_POS: setpoint <= pos_new;
        trap_pkg::OP_DECIDE: begin
          if (mode_reg == trap_pkg::MODE_ACC) begin
            if (brake_now) mode_reg <= trap_pkg::MODE_BRK;
          end else begin
            speed_reached <= 1'b0;
            if (forward ? (velocity <= 0) : (velocity >= 0)) mode_reg <= trap_pkg::MODE_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tick_q <= tick_prod[60:trap_pkg::RECIP_SH];
    case (cmd.op)
      trap_pkg::OP_LOAD: begin
        in_kind <= kind;
        in_tpos <= target_position;
        in_tspd <= target_speed;
        in_meas <= measured_position;
      end
      trap_pkg::OP_DIV_A: begin
        q_neg    <= accel_s[31];
        tick_num <= tick_sum[32:3];
      end
      trap_pkg::OP_DIV_V: begin
        q_neg    <= velocity[31];
        tick_num <= tick_sum[32:3];
      end
      trap_pkg::OP_MUL:   prod  <= vel_mag * vel_mag;
      trap_pkg::OP_OUT: begin
        commanded_position <= setpoint;
        mode               <= mode_reg;
        at_speed           <= speed_reached;
        profile_speed      <= velocity;
      end
      default: ;
    endcase
  end

  assign stat.kind     = in_kind;
  assign stat.mode     = mode_reg;
  assign stat.out_full = out_valid && !out_ready;
  assign stat.div_done = div_done;

endmodule

/* design/trapezoid_motion_profile_top.sv */
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_top
// Trapezoidal move generator, Q16.16, one result item per input item.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   cfg      cfg_we                cfg_index, cfg_data
//   in       in_valid / in_ready   kind, target_position, target_speed,
//                                  measured_position
//   out      out_valid / out_ready commanded_position, mode, at_speed,
//                                  profile_speed
//
// A goto and an idle/requested/reached tick go straight from dispatch to
// output; a braking tick first steps the velocity and the position by their
// per-tick shares, and an accelerating tick also runs the braking-distance
// divide on the serial divider. Each per-tick share is a reciprocal multiply.
// One item is in flight at a time; the output register lets the next item
// enter while a result waits. Synchronous reset restores ctrl, cfg, profile.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [trap_pkg::ACC_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic signed [trap_pkg::POS_W-1:0] target_position,
  input  logic [trap_pkg::SPD_W-1:0]        target_speed,
  input  logic signed [trap_pkg::POS_W-1:0] measured_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [trap_pkg::POS_W-1:0] commanded_position,
  output logic [2:0]                        mode,
  output logic                              at_speed,
  output logic signed [31:0]                profile_speed
);

  trap_pkg::cmd_t    cmd;
  trap_pkg::status_t stat;

  trap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trap_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .kind               (kind),
    .target_position    (target_position),
    .target_speed       (target_speed),
    .measured_position  (measured_position),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .commanded_position (commanded_position),
    .mode               (mode),
    .at_speed           (at_speed),
    .profile_speed      (profile_speed),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

/* design/trap_checker.sv */
// ----------------------------------------------------------------------------
// trap_checker
// Port-level checks for the profile generator.
// ----------------------------------------------------------------------------
module trap_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] commanded_position,
  input logic [31:0] profile_speed
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(commanded_position)
      && $stable(profile_speed))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // a new result only follows work on an item
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item");

endmodule

bind trapezoid_motion_profile_top trap_checker u_trap_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .commanded_position (commanded_position),
  .profile_speed      (profile_speed)
);
